// ===== rtl/autocorr_peak_finder_unit_macros.svh =====
// Assertion macros for the autocorrelation peak finder.
// Needs signals named clock and reset in the module that uses them.
`ifndef AUTOCORR_PEAK_FINDER_UNIT_MACROS_SVH
`define AUTOCORR_PEAK_FINDER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked out of reset
`define ACPF_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked out of reset
`define ACPF_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`else

`define ACPF_ASSERT_IMPL(lbl, ante, cons, msg)
`define ACPF_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== rtl/acpf_pkg.sv =====
// Shared types and constants for the autocorrelation peak finder.
// No dependencies; used by every module of the block.
package acpf_pkg;

   localparam int PEAK_LIMIT_DEF = 128;
   localparam int COUNT_W        = 8;
   localparam int LAG_W          = 8;
   localparam int SAMPLE_W       = 16;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic [LAG_W-1:0]           lag_type;
   typedef logic [COUNT_W-1:0]         count_type;

   localparam lag_type   LAG_MAX   = '1;
   localparam count_type COUNT_MAX = '1;

   // One accepted input item
   typedef struct packed {
      sample_type sample;
      logic       first;
      logic       last;
   } item_type;

   // Results caused by one item: optional peak record, optional summary
   typedef struct packed {
      logic       peak_vld;
      logic       sum_vld;
      sample_type peak_value;
      lag_type    peak_lag;
      sample_type frame_value;
      lag_type    frame_lag;
      count_type  count;
   } rec_type;

endpackage

// ===== rtl/autocorr_peak_finder_unit.sv =====
// A result passes through the input register, then the result queue; throughput one
// item and one result per cycle while rsp_tready is high and no item causes two results.
// An item that causes two results holds the result side for two handshakes; the
// two-entry result queue sets how long the input side keeps running meanwhile.
// Reset (synchronous, active high) clears the tracking state as for a frame whose
// lag zero held a zero sample, and empties both registers stages.
module autocorr_peak_finder_unit
   import acpf_pkg::*;
#(
   parameter int PEAK_LIMIT = PEAK_LIMIT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] sample
   input  logic        req_tuser,   // [0] first_of_frame
   input  logic        req_tlast,   // last_of_frame
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [15:0] value, [23:16] lag, [31:24] peak_count
   output logic        rsp_tuser,   // [0] is_summary
   output logic        rsp_tlast    // last_result
);

   logic       in_vld_ff;
   item_type   in_ff;
   logic       step_go;
   logic       push_ok;
   rec_type    rec;
   sample_type out_value;
   lag_type    out_lag;
   count_type  out_count;

   assign step_go    = in_vld_ff && push_ok;
   assign req_tready = !in_vld_ff || step_go;

   // Hold the accepted item in the input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_tready) begin
         in_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_ff.sample <= sample_type'(req_tdata);
         in_ff.first  <= req_tuser;
         in_ff.last   <= req_tlast;
      end
   end

   acpf_core #(
      .PEAK_LIMIT (PEAK_LIMIT)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .step_go (step_go),
      .item    (in_ff),
      .rec     (rec)
   );

   acpf_rsp_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (step_go && (rec.peak_vld || rec.sum_vld)),
      .push_rec    (rec),
      .push_ok     (push_ok),
      .out_vld     (rsp_tvalid),
      .out_rdy     (rsp_tready),
      .out_summary (rsp_tuser),
      .out_value   (out_value),
      .out_lag     (out_lag),
      .out_count   (out_count),
      .out_last    (rsp_tlast)
   );

   // Pack the result fields
   assign rsp_tdata = {out_count, out_lag, out_value};

endmodule

// ===== rtl/acpf_core.sv =====
// Lobe and frame tracking state with its per-item update logic.
// Depends on acpf_pkg.
module acpf_core
   import acpf_pkg::*;
#(
   parameter int PEAK_LIMIT = PEAK_LIMIT_DEF
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     step_go,
   input  item_type item,
   output rec_type  rec
);

   localparam count_type CountCap = (PEAK_LIMIT > 255) ? COUNT_MAX : count_type'(PEAK_LIMIT);

   sample_type prev_ff, prev_in;
   logic       cross_ff, cross_in;
   sample_type lobe_val_ff, lobe_val_in;
   lag_type    lobe_lag_ff, lobe_lag_in;
   sample_type frame_val_ff, frame_val_in;
   lag_type    frame_lag_ff, frame_lag_in;
   count_type  peaks_ff, peaks_in;
   lag_type    lag_ff, lag_in;
   logic       peak_vld;

   // Work out the next tracking state and any peak record
   always_comb begin
      prev_in      = prev_ff;
      cross_in     = cross_ff;
      lobe_val_in  = lobe_val_ff;
      lobe_lag_in  = lobe_lag_ff;
      frame_val_in = frame_val_ff;
      frame_lag_in = frame_lag_ff;
      peaks_in     = peaks_ff;
      lag_in       = lag_ff;
      peak_vld     = 1'b0;
      if (item.first) begin
         // lag zero: restart the frame
         prev_in      = item.sample;
         cross_in     = 1'b0;
         lobe_val_in  = '0;
         lobe_lag_in  = '0;
         frame_val_in = '0;
         frame_lag_in = '0;
         peaks_in     = '0;
         lag_in       = '0;
      end else begin
         if (lag_ff != LAG_MAX) begin
            lag_in = lag_ff + lag_type'(1);
         end
         if (cross_ff) begin
            if (!prev_ff[SAMPLE_W-1] && !item.sample[SAMPLE_W-1]) begin
               // inside a lobe: follow its maximum
               if (item.sample > lobe_val_ff) begin
                  lobe_val_in = item.sample;
                  lobe_lag_in = lag_in;
                  if (item.sample > frame_val_ff) begin
                     frame_val_in = item.sample;
                     frame_lag_in = lag_in;
                  end
               end
            end else if (!prev_ff[SAMPLE_W-1] && item.sample[SAMPLE_W-1]
                         && (frame_val_ff > sample_type'(0))) begin
               // lobe ends: count and report its peak
               if (peaks_ff < CountCap) begin
                  peaks_in = peaks_ff + count_type'(1);
               end
               peak_vld = 1'b1;
            end else if (prev_ff[SAMPLE_W-1] && !item.sample[SAMPLE_W-1]) begin
               // lobe entry: seed the lobe maximum with this lag
               lobe_val_in = item.sample;
               lobe_lag_in = lag_in;
               if (item.sample > frame_val_ff) begin
                  frame_val_in = item.sample;
                  frame_lag_in = lag_in;
               end
            end
         end else if (item.sample <= sample_type'(0)) begin
            cross_in = 1'b1;
         end
         prev_in = item.sample;
      end
   end

   // Results of this item
   always_comb begin
      rec.peak_vld    = peak_vld;
      rec.sum_vld     = item.last;
      rec.peak_value  = lobe_val_ff;
      rec.peak_lag    = lobe_lag_ff;
      rec.frame_value = frame_val_in;
      rec.frame_lag   = frame_lag_in;
      rec.count       = peaks_in;
   end

   // Advance the state on each processed item
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff      <= '0;
         cross_ff     <= 1'b0;
         lobe_val_ff  <= '0;
         lobe_lag_ff  <= '0;
         frame_val_ff <= '0;
         frame_lag_ff <= '0;
         peaks_ff     <= '0;
         lag_ff       <= '0;
      end else if (step_go) begin
         prev_ff      <= prev_in;
         cross_ff     <= cross_in;
         lobe_val_ff  <= lobe_val_in;
         lobe_lag_ff  <= lobe_lag_in;
         frame_val_ff <= frame_val_in;
         frame_lag_ff <= frame_lag_in;
         peaks_ff     <= peaks_in;
         lag_ff       <= lag_in;
      end
   end

endmodule

// ===== rtl/acpf_rsp_queue.sv =====
// Two-entry result queue: each entry holds the records of one item,
// delivered one record per handshake, peak record before summary.
// Depends on acpf_pkg and the assertion macro header.
`include "autocorr_peak_finder_unit_macros.svh"

module acpf_rsp_queue
   import acpf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  rec_type    push_rec,
   output logic       push_ok,
   output logic       out_vld,
   input  logic       out_rdy,
   output logic       out_summary,
   output sample_type out_value,
   output lag_type    out_lag,
   output count_type  out_count,
   output logic       out_last
);

   rec_type    q_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] cnt_ff, cnt_in;
   logic       half_ff;
   rec_type    head;
   logic       fire, pop;

   // Present the head entry
   always_comb begin
      head        = q_ff[rd_ptr_ff];
      out_vld     = (cnt_ff != 2'd0);
      out_summary = !head.peak_vld || half_ff;
      out_value   = out_summary ? head.frame_value : head.peak_value;
      out_lag     = out_summary ? head.frame_lag : head.peak_lag;
      out_count   = head.count;
      out_last    = out_summary || !head.sum_vld;
      fire        = out_vld && out_rdy;
      pop         = fire && out_last;
      push_ok     = (cnt_ff != 2'd2) || pop;
      cnt_in      = cnt_ff + 2'(push) - 2'(pop);
   end

   // Store pushed entries
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= push_rec;
      end
   end

   // Advance pointers, fill level and the within-entry position
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
         half_ff   <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
            half_ff   <= 1'b0;
         end else if (fire) begin
            half_ff   <= 1'b1;
         end
      end
   end

   `ACPF_ASSERT_IMPL(a_cnt_range, 1'b1, cnt_ff <= 2'd2, "result queue over its depth")
   `ACPF_ASSERT_IMPL(a_push_room, push, push_ok, "push into a full result queue")
   `ACPF_ASSERT_IMPL(a_push_nonempty, push, push_rec.peak_vld || push_rec.sum_vld, "empty entry")
   `ACPF_ASSERT_IMPL(a_half_pair, half_ff, out_vld && head.peak_vld && head.sum_vld, "lone half")

endmodule
